### src/dts_pkg.sv
// Shared types and constants for the depth-first topological sorter.
package dts_pkg;

  localparam int unsigned MaxNodes = 64;
  localparam int unsigned MaxLinks = 256;
  localparam int unsigned NodeW    = $clog2(MaxNodes);
  localparam int unsigned LinkW    = $clog2(MaxLinks);
  localparam int unsigned CountW   = LinkW + 1;
  localparam int unsigned TotalW   = 7;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_SORT  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_CYCLE = 2'd1;
  localparam logic [1:0] ERR_LOAD  = 2'd2;

  localparam logic [1:0] MARK_NEW  = 2'd0;
  localparam logic [1:0] MARK_BUSY = 2'd1;
  localparam logic [1:0] MARK_DONE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK_RD,
    ST_CHECK,
    ST_CLEAR,
    ST_ROOT,
    ST_SCAN_RD,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK,
    ST_EMIT_RD,
    ST_EMIT,
    ST_ERR
  } state_t;

endpackage

### src/dts_if.sv
// Valid/ready channel interfaces for command and result words.
interface dts_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [5:0] from_node;
  logic [5:0] to_node;
  modport source (output valid, cmd, from_node, to_node, input ready);
  modport sink (input valid, cmd, from_node, to_node, output ready);
endinterface

interface dts_res_if;
  logic       valid;
  logic       ready;
  logic [5:0] node_index;
  logic [1:0] error_code;
  logic       is_last;
  modport source (output valid, node_index, error_code, is_last, input ready);
  modport sink (input valid, node_index, error_code, is_last, output ready);
endinterface

### src/dfs_topological_sort.sv
// Top level: link store, depth-first walk sequencer and result register.
//   channel   dir  words
//   in_ch     in   cmd, from_node, to_node
//   out_ch    out  node_index, error_code, is_last
//   cfg       in   node_total (wr_en, wr_data)
// Add, clear and the spare command are handled in the idle state. A sort checks
// the range of each held link, clears all 64 marks, scans the links from each
// node's frame, reads the mark of each matched link's source and visits each
// root. Results stall the walk only at emission. Reset is synchronous; the link
// memory needs no clearing since only entries below the fill count are used.
module dfs_topological_sort (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [6:0] wr_data,
  dts_cmd_if.sink    in_ch,
  dts_res_if.source  out_ch
);

  localparam int unsigned NW = dts_pkg::NodeW;
  localparam int unsigned LW = dts_pkg::LinkW;
  localparam int unsigned CW = dts_pkg::CountW;

  logic [6:0]     node_total;
  logic [CW-1:0]  links_held;
  logic           overflow;
  dts_pkg::state_t state, state_next;

  // link memory: {source, dest}
  logic [2*NW-1:0] link_mem [dts_pkg::MaxLinks];
  logic [2*NW-1:0] link_q;
  logic [LW-1:0]   link_ra;
  logic            link_we;
  logic [1:0]      mark_mem [dts_pkg::MaxNodes];
  logic [1:0]      mark_q;
  logic [NW-1:0]   mark_ra, mark_wa;
  logic [1:0]      mark_wd;
  logic            mark_we;
  logic [NW+CW-1:0] stk_mem [dts_pkg::MaxNodes];
  logic [NW+CW-1:0] stk_q;
  logic [NW-1:0]   ord_mem [dts_pkg::MaxNodes];
  logic [NW-1:0]   ord_q;

  logic [NW:0]     n_eff;
  logic [CW-1:0]   cur;     // link cursor of top frame
  logic [NW-1:0]   top;     // node of top frame
  logic [NW:0]     sp;      // frames on stack
  logic [NW:0]     root;
  logic [NW:0]     fill;
  logic [NW:0]     idx;     // clear and emit counter
  logic [NW-1:0]   src_hold;

  logic           res_valid;
  logic [NW-1:0]  res_node;
  logic [1:0]     res_err;
  logic           res_last;

  assign n_eff = (node_total == 7'd0) ? (NW+1)'(1) :
                 (node_total > 7'(dts_pkg::MaxNodes)) ? (NW+1)'(dts_pkg::MaxNodes)
                 : (NW+1)'(node_total);

  wire out_free = !res_valid || out_ch.ready;
  wire accept   = in_ch.valid && in_ch.ready;
  wire bad_add  = ({1'b0, in_ch.from_node} >= n_eff) || ({1'b0, in_ch.to_node} >= n_eff)
                  || (links_held >= CW'(dts_pkg::MaxLinks));
  wire [NW-1:0] lsrc = link_q[2*NW-1:NW];
  wire [NW-1:0] ldst = link_q[NW-1:0];
  // parent frame, registered read ahead of a pop
  wire [NW-1:0] stk_ra = NW'(sp - (NW+1)'(2));
  wire res_load = (accept && in_ch.cmd == dts_pkg::CMD_ADD && bad_add)
                  || ((state inside {dts_pkg::ST_EMIT, dts_pkg::ST_ERR}) && out_free);

  assign in_ch.ready = (state == dts_pkg::ST_IDLE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) node_total <= 7'd64;
    else if (wr_en) node_total <= wr_data;
  end

  assign link_we = accept && in_ch.cmd == dts_pkg::CMD_ADD && !bad_add;

  always_ff @(posedge clk) begin
    if (link_we) link_mem[links_held[LW-1:0]] <= {in_ch.from_node, in_ch.to_node};
    link_q <= link_mem[link_ra];
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    mark_q <= mark_mem[mark_ra];
    ord_q <= ord_mem[idx[NW-1:0]];
    stk_q <= stk_mem[stk_ra];
  end

  always_comb begin
    state_next = state;
    case (state)
      dts_pkg::ST_IDLE:
        if (accept && in_ch.cmd == dts_pkg::CMD_SORT) begin
          if (overflow) state_next = dts_pkg::ST_ERR;
          else if (links_held == '0) state_next = dts_pkg::ST_CLEAR;
          else state_next = dts_pkg::ST_CHECK_RD;
        end
      dts_pkg::ST_CHECK_RD: state_next = dts_pkg::ST_CHECK;
      dts_pkg::ST_CHECK:
        if ({1'b0, lsrc} >= n_eff || {1'b0, ldst} >= n_eff) state_next = dts_pkg::ST_ERR;
        else if (cur == links_held) state_next = dts_pkg::ST_CLEAR;
        else state_next = dts_pkg::ST_CHECK_RD;
      dts_pkg::ST_CLEAR:
        if (idx == (NW+1)'(dts_pkg::MaxNodes - 1)) state_next = dts_pkg::ST_ROOT;
      dts_pkg::ST_ROOT:
        if (root == n_eff) state_next = (fill == '0) ? dts_pkg::ST_IDLE : dts_pkg::ST_EMIT_RD;
        else state_next = dts_pkg::ST_MARK_RD;
      dts_pkg::ST_SCAN_RD: state_next = dts_pkg::ST_SCAN;
      dts_pkg::ST_SCAN:
        if (cur > links_held)
          state_next = (sp == (NW+1)'(1)) ? dts_pkg::ST_ROOT : dts_pkg::ST_SCAN_RD;
        else if (ldst == top) state_next = dts_pkg::ST_MARK_RD;
        else state_next = dts_pkg::ST_SCAN_RD;
      dts_pkg::ST_MARK_RD: state_next = dts_pkg::ST_MARK;
      dts_pkg::ST_MARK:
        if (mark_q == dts_pkg::MARK_BUSY) state_next = dts_pkg::ST_ERR;
        else if (sp == '0 && mark_q != dts_pkg::MARK_NEW) state_next = dts_pkg::ST_ROOT;
        else state_next = dts_pkg::ST_SCAN_RD;
      dts_pkg::ST_EMIT_RD: state_next = dts_pkg::ST_EMIT;
      dts_pkg::ST_EMIT:
        if (out_free) state_next = (idx + 1'b1 == fill) ? dts_pkg::ST_IDLE : dts_pkg::ST_EMIT_RD;
      dts_pkg::ST_ERR: if (out_free) state_next = dts_pkg::ST_IDLE;
      default: state_next = dts_pkg::ST_IDLE;
    endcase
  end

  // memory addresses and mark writes
  always_comb begin
    link_ra = cur[LW-1:0];
    mark_ra = (sp == '0) ? root[NW-1:0] : src_hold;
    mark_we = 1'b0;
    mark_wa = idx[NW-1:0];
    mark_wd = dts_pkg::MARK_NEW;
    case (state)
      dts_pkg::ST_CLEAR: mark_we = 1'b1;
      dts_pkg::ST_SCAN:
        if (cur > links_held) begin
          mark_we = 1'b1;
          mark_wa = top;
          mark_wd = dts_pkg::MARK_DONE;
        end
      dts_pkg::ST_MARK:
        if (mark_q == dts_pkg::MARK_NEW) begin
          mark_we = 1'b1;
          mark_wa = mark_ra;
          mark_wd = dts_pkg::MARK_BUSY;
        end
      default: mark_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dts_pkg::ST_IDLE;
      links_held <= '0;
      overflow <= 1'b0;
      res_valid <= 1'b0;
      cur <= '0; sp <= '0; root <= '0; fill <= '0; idx <= '0;
    end else begin
      state <= state_next;
      if (res_load) res_valid <= 1'b1;
      else if (out_ch.ready) res_valid <= 1'b0;
      case (state)
        dts_pkg::ST_IDLE: begin
          cur <= '0; sp <= '0; root <= '0; fill <= '0; idx <= '0;
          if (accept) begin
            case (in_ch.cmd)
              dts_pkg::CMD_ADD:
                if (bad_add) begin
                  overflow <= 1'b1;
                  res_node <= '0;
                  res_err <= dts_pkg::ERR_LOAD; res_last <= 1'b1;
                end else links_held <= links_held + 1'b1;
              dts_pkg::CMD_SORT: res_err <= dts_pkg::ERR_LOAD;
              dts_pkg::CMD_CLEAR: begin
                links_held <= '0;
                overflow <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        dts_pkg::ST_CHECK_RD: cur <= cur + 1'b1;
        dts_pkg::ST_CHECK: begin
          res_err <= dts_pkg::ERR_LOAD;
          if (state_next == dts_pkg::ST_CLEAR) cur <= '0;
        end
        dts_pkg::ST_CLEAR: idx <= idx + 1'b1;
        dts_pkg::ST_ROOT: idx <= '0;
        dts_pkg::ST_SCAN_RD: cur <= cur + 1'b1;
        dts_pkg::ST_SCAN:
          if (cur > links_held) begin
            ord_mem[fill[NW-1:0]] <= top;
            fill <= fill + 1'b1;
            sp <= sp - 1'b1;
            if (sp != (NW+1)'(1)) begin
              top <= stk_q[NW+CW-1:CW];
              cur <= stk_q[CW-1:0];
            end
          end else if (ldst == top) src_hold <= lsrc;
        dts_pkg::ST_MARK: begin
          res_err <= dts_pkg::ERR_CYCLE;
          if (sp == '0) root <= root + 1'b1;
          if (mark_q == dts_pkg::MARK_NEW) begin
            // save parent cursor, push child
            if (sp != '0) stk_mem[NW'(sp - 1'b1)] <= {top, cur};
            top <= mark_ra;
            cur <= '0;
            sp <= sp + 1'b1;
          end
        end
        dts_pkg::ST_EMIT:
          if (out_free) begin
            res_node <= ord_q;
            res_err <= dts_pkg::ERR_OK;
            res_last <= (idx + 1'b1 == fill);
            idx <= idx + 1'b1;
          end
        dts_pkg::ST_ERR:
          if (out_free) begin
            res_node <= '0; res_last <= 1'b1;
          end
        default: ;
      endcase
    end
  end

  assign out_ch.valid      = res_valid;
  assign out_ch.node_index = res_node;
  assign out_ch.error_code = res_err;
  assign out_ch.is_last    = res_last;

  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    links_held <= CW'(dts_pkg::MaxLinks)) else $error("link count past capacity");
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= (NW+1)'(dts_pkg::MaxNodes)) else $error("stack overrun");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_err != dts_pkg::ERR_OK |-> res_last && res_node == '0)
    else $error("error word not single");
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == dts_pkg::ST_IDLE) else $error("ready outside idle");

endmodule
